// ===== sv/mm4_pkg.sv =====
// mm4_pkg: shared types and defaults for the 4x4 matrix multiply unit
// holds the controller state type and the command/status structs
// used by mm4_ctrl, mm4_datapath and matrix_multiply_4x4_unit

package mm4_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAT_DIM        = 4;
    localparam int ROW_IDX_W      = 2;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_CALC
    } mm4_state_t;

    // controller -> datapath
    typedef struct packed {
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_row;
        logic                 issue;
        logic [ROW_IDX_W-1:0] issue_row;
    } mm4_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic advance;
    } mm4_status_t;

endpackage

// ===== sv/mm4_ctrl.sv =====
// mm4_ctrl: controller for the 4x4 matrix multiply unit
// counts loaded rows, then issues the four product rows into the datapath
// depends on mm4_pkg

module mm4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mm4_pkg::mm4_status_t status,
    output mm4_pkg::mm4_cmd_t    cmd
);

    mm4_pkg::mm4_state_t                state_reg, state_next;
    logic [mm4_pkg::ROW_IDX_W-1:0]      rows_reg, rows_next;
    logic [mm4_pkg::ROW_IDX_W-1:0]      issue_cnt_reg, issue_cnt_next;

    localparam logic [mm4_pkg::ROW_IDX_W-1:0] LAST_ROW =
        mm4_pkg::ROW_IDX_W'(mm4_pkg::MAT_DIM - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mm4_pkg::ST_LOAD;
            rows_reg      <= '0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        issue_cnt_next = issue_cnt_reg;
        s_tready       = 1'b0;
        cmd.wr_en      = 1'b0;
        cmd.wr_row     = rows_reg;
        cmd.issue      = 1'b0;
        cmd.issue_row  = issue_cnt_reg;
        case (state_reg)
            mm4_pkg::ST_LOAD:
            begin
                s_tready  = 1'b1;
                cmd.wr_en = s_tvalid;
                if (s_tvalid)
                begin
                    rows_next = rows_reg + 1'b1;
                    if (rows_reg == LAST_ROW)
                    begin
                        issue_cnt_next = '0;
                        state_next     = mm4_pkg::ST_CALC;
                    end
                end
            end
            mm4_pkg::ST_CALC:
            begin
                // one product row enters the multipliers whenever the pipe moves
                cmd.issue = status.advance;
                if (status.advance)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    if (issue_cnt_reg == LAST_ROW)
                        state_next = mm4_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mm4_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== sv/mm4_datapath.sv =====
// mm4_datapath: row stores, sixteen multipliers and four summing lanes
// stage 1 registers the exact products, stage 2 sums, shifts and saturates
// depends on mm4_pkg

module mm4_datapath #(
    parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mm4_pkg::mm4_cmd_t             cmd,
    output mm4_pkg::mm4_status_t          status,
    input  logic [8*DATA_WIDTH-1:0]       in_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4*DATA_WIDTH-1:0]       out_row,
    output logic [mm4_pkg::ROW_IDX_W-1:0] out_idx,
    output logic                          out_last
);

    localparam int DIM    = mm4_pkg::MAT_DIM;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam int HI_W   = ACC_W - DATA_WIDTH + 1;

    localparam logic [mm4_pkg::ROW_IDX_W-1:0] LAST_ROW =
        mm4_pkg::ROW_IDX_W'(DIM - 1);
    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // stores: a is read one row at a time, b is read whole
    logic [DATA_WIDTH-1:0] a_mem [DIM][DIM];
    logic [DATA_WIDTH-1:0] b_mem [DIM][DIM];

    logic signed [PROD_W-1:0]      prod_reg [DIM][DIM];
    logic signed [PROD_W-1:0]      prod_next [DIM][DIM];
    logic                          p_valid_reg;
    logic [mm4_pkg::ROW_IDX_W-1:0] p_row_reg;

    logic                          o_valid_reg;
    logic [mm4_pkg::ROW_IDX_W-1:0] o_row_reg;
    logic [4*DATA_WIDTH-1:0]       o_data_reg, o_data_next;

    logic advance;

    assign advance        = !o_valid_reg || out_ready;
    assign status.advance = advance;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                a_mem[cmd.wr_row][j] <= in_row[j*DATA_WIDTH +: DATA_WIDTH];
                b_mem[cmd.wr_row][j] <= in_row[(DIM+j)*DATA_WIDTH +: DATA_WIDTH];
            end
        end
    end

    // prod_next[j][k] = a[i][k] * b[k][j]
    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                prod_next[j][k] = $signed(a_mem[cmd.issue_row][k])
                                * $signed(b_mem[k][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cmd.issue)
        begin
            prod_reg  <= prod_next;
            p_row_reg <= cmd.issue_row;
        end
        if (advance && p_valid_reg)
        begin
            o_data_reg <= o_data_next;
            o_row_reg  <= p_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= cmd.issue;
            o_valid_reg <= p_valid_reg;
        end
    end

    // exact sum, arithmetic shift, saturate to the word width
    always_comb
    begin
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] shifted;
        logic [HI_W-1:0]         hi;
        o_data_next = '0;
        for (int j = 0; j < DIM; j++)
        begin
            sum = '0;
            for (int k = 0; k < DIM; k++)
            begin
                sum = sum + {{2{prod_reg[j][k][PROD_W-1]}}, prod_reg[j][k]};
            end
            shifted = sum >>> FRAC_BITS;
            hi      = shifted[ACC_W-1:DATA_WIDTH-1];
            if (!(&hi) && (|hi))
                o_data_next[j*DATA_WIDTH +: DATA_WIDTH] =
                    shifted[ACC_W-1] ? MIN_VAL : MAX_VAL;
            else
                o_data_next[j*DATA_WIDTH +: DATA_WIDTH] = shifted[DATA_WIDTH-1:0];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_row   = o_data_reg;
    assign out_idx   = o_row_reg;
    assign out_last  = (o_row_reg == LAST_ROW);

endmodule

// ===== sv/matrix_multiply_4x4_unit.sv =====
// 4x4 fixed-point matrix multiply, C = A * B, row-major. Each input word
// carries one row of A and the same row of B; after the fourth word the unit
// emits the four rows of C in order, each entry the exact sum of four signed
// products, shifted right arithmetically by FRAC_BITS and saturated to
// DATA_WIDTH bits. Rows load at one word per cycle while s_tready is high; the
// fourth word is followed by the issue phase (s_tready low), one product row per
// cycle through sixteen multipliers while the output advances. Each issued row
// passes the product register, then the output register, which lets the next
// matrix load while results still wait.

module matrix_multiply_4x4_unit #(
    parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // a_col0, a_col1, a_col2, a_col3, b_col0, b_col1, b_col2, b_col3
    input  logic [((8*DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // c_col0, c_col1, c_col2, c_col3
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
    // row_index
    output logic [mm4_pkg::ROW_IDX_W-1:0]        m_tuser,
    output logic                                 m_tlast
);

    localparam int M_TDATA_W = ((4*DATA_WIDTH+7)/8)*8;

    mm4_pkg::mm4_cmd_t    cmd;
    mm4_pkg::mm4_status_t status;
    logic [4*DATA_WIDTH-1:0] out_row;

    mm4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mm4_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_row    (s_tdata[8*DATA_WIDTH-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_idx   (m_tuser),
        .out_last  (m_tlast)
    );

    // zero fill up to whole bytes
    assign m_tdata = M_TDATA_W'(out_row);

endmodule

// ===== tb/sv/matrix_multiply_4x4_unit_tb.sv =====
// testbench for matrix_multiply_4x4_unit: streams row pairs of A and B, predicts
// every product row in Q16.16 with saturation and checks each output word in order
// depends on mm4_pkg and matrix_multiply_4x4_unit
`timescale 1ns / 1ps

module matrix_multiply_4x4_unit_tb;

    localparam int DW          = mm4_pkg::DATA_WIDTH_DEF;
    localparam int FRAC        = mm4_pkg::FRAC_BITS_DEF;
    localparam int DIM         = mm4_pkg::MAT_DIM;
    localparam int RAND_GROUPS = 47;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 60;

    localparam logic [DW-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DW-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [DW-1:0] Q_LSB  = 32'h0000_0001;
    localparam logic [DW-1:0] Q_NLSB = 32'hFFFF_FFFF;

    localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

    // one input word: a_col0..3 then b_col0..3, plus an optional typed-in result
    typedef struct packed {
        logic [2*DIM-1:0][DW-1:0] cols;
        bit                       typed;
        logic [DW-1:0]            c_all;
    } stim_row_t;

    typedef struct packed {
        logic [DIM-1:0][DW-1:0]            c;
        logic [mm4_pkg::ROW_IDX_W-1:0]     row;
        logic                              last;
    } product_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [8*DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [4*DW-1:0] m_tdata;
    logic [mm4_pkg::ROW_IDX_W-1:0] m_tuser;
    logic m_tlast;

    matrix_multiply_4x4_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stim_row_t      directed_rows[$];
    product_row_t   product_rows_q[$];
    logic [DW-1:0]  a_held[DIM][DIM];
    logic [DW-1:0]  b_held[DIM][DIM];
    int             rows_held = 0;
    int             words_in = 0;
    int             mismatches = 0;
    int             cycles = 0;
    bit             hold_off = 0;
    bit             cur_typed = 0;
    logic [DW-1:0]  cur_c_all = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // store one row pair; the fourth row of a group yields four product rows
    task automatic load_and_multiply(input logic [8*DW-1:0] word, input bit typed,
                                     input logic [DW-1:0] c_all);
        product_row_t             pr;
        logic signed [DW-1:0]     a_v;
        logic signed [DW-1:0]     b_v;
        longint                   prod;
        logic signed [65:0]       acc;
        logic signed [65:0]       shifted;
        for (int j = 0; j < DIM; j++)
        begin
            a_held[rows_held][j] = word[j*DW +: DW];
            b_held[rows_held][j] = word[(DIM+j)*DW +: DW];
        end
        if (rows_held != DIM-1)
        begin
            rows_held++;
            return;
        end
        rows_held = 0;
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                acc = '0;
                for (int k = 0; k < DIM; k++)
                begin
                    a_v  = a_held[i][k];
                    b_v  = b_held[k][j];
                    prod = longint'(a_v) * longint'(b_v);
                    acc  = acc + $signed({{2{prod[63]}}, prod});
                end
                // arithmetic shift rounds toward minus infinity
                shifted = acc >>> FRAC;
                if (shifted > SUM_MAX)
                    pr.c[j] = Q_MAX;
                else if (shifted < SUM_MIN)
                    pr.c[j] = Q_MIN;
                else
                    pr.c[j] = shifted[DW-1:0];
                if (typed)
                    pr.c[j] = c_all;
            end
            pr.row  = i[mm4_pkg::ROW_IDX_W-1:0];
            pr.last = (i == DIM-1);
            product_rows_q.push_back(pr);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [DW-1:0] exp_v,
                                 input logic [DW-1:0] got_v);
        if (mismatches < 10)
            $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, exp_v,
                     got_v);
        mismatches++;
    endtask

    // accepted words on both sides, sampled at the rising edge
    always @(posedge clk)
    begin
        product_row_t pr;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                load_and_multiply(s_tdata, cur_typed, cur_c_all);
                words_in <= words_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (product_rows_q.size() == 0)
                    note_mismatch("unexpected word, row", '0, DW'(m_tuser));
                else
                begin
                    pr = product_rows_q.pop_front();
                    for (int j = 0; j < DIM; j++)
                        if (m_tdata[j*DW +: DW] !== pr.c[j])
                            note_mismatch($sformatf("row %0d c_col%0d", pr.row, j), pr.c[j],
                                          m_tdata[j*DW +: DW]);
                    if (m_tuser !== pr.row)
                        note_mismatch("row_index", DW'(pr.row), DW'(m_tuser));
                    if (m_tlast !== pr.last)
                        note_mismatch($sformatf("row %0d last_row", pr.row), DW'(pr.last),
                                      DW'(m_tlast));
                end
            end
        end
    end

    // receiver: stretches of steady ready, random ready and stalls
    initial
    begin
        int n;
        int style;
        forever
        begin
            n     = $urandom_range(1, 40);
            style = $urandom_range(0, 9);
            if (style == 8 && $urandom_range(0, 3) != 0)
                n = $urandom_range(1, 4);
            repeat (n)
            begin
                @(negedge clk);
                if (hold_off)
                    m_tready <= 1'b0;
                else if (style <= 3)
                    m_tready <= 1'b1;
                else if (style <= 7)
                    m_tready <= ($urandom_range(0, 3) != 0);
                else if (style == 8)
                    m_tready <= 1'b0;
                else
                    m_tready <= 1'($urandom_range(0, 1));
            end
        end
    end

    // one long hold-off so the output fills up and the input stalls
    initial
    begin
        wait (words_in >= HOLD_AFTER);
        @(posedge clk);
        hold_off = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 0;
    end

    function automatic logic [DW-1:0] rand_q16();
        logic [DW-1:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            v = $urandom;
        else if (sel <= 6)
            v = DW'($urandom_range(0, 1 << 20));
        else if (sel == 7)
            v = DW'($urandom_range(0, 1 << 24));
        else
        begin
            case ($urandom_range(0, 5))
                0: v = Q_MAX;
                1: v = Q_MIN;
                2: v = Q_ZERO;
                3: v = Q_NLSB;
                4: v = Q_ONE;
                default: v = Q_LSB;
            endcase
            return v;
        end
        if (sel >= 4 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic stim_row_t uniform_row(input logic [DW-1:0] a_v,
                                              input logic [DW-1:0] b_v, input bit typed,
                                              input logic [DW-1:0] c_all);
        stim_row_t r;
        for (int j = 0; j < DIM; j++)
        begin
            r.cols[j]     = a_v;
            r.cols[DIM+j] = b_v;
        end
        r.typed = typed;
        r.c_all = c_all;
        return r;
    endfunction

    task automatic push_uniform_group(input logic [DW-1:0] a_v, input logic [DW-1:0] b_v,
                                      input logic [DW-1:0] c_all);
        for (int r = 0; r < DIM; r++)
            directed_rows.push_back(uniform_row(a_v, b_v, r == DIM-1, c_all));
    endtask

    // drive one word after a random gap, hold it until accepted
    task automatic send_word(input stim_row_t r);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            gap = 0;
        else if (roll < 88)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 50);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= r.cols;
        cur_typed  = r.typed;
        cur_c_all  = r.c_all;
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        @(negedge clk);
    endtask

    initial
    begin
        stim_row_t r;
        // zeros, saturation both ways, and -1 lsb from rounding toward minus infinity
        push_uniform_group(Q_ZERO, Q_ZERO, Q_ZERO);
        push_uniform_group(Q_MAX, Q_MAX, Q_MAX);
        push_uniform_group(Q_MIN, Q_MIN, Q_MAX);
        push_uniform_group(Q_MAX, Q_MIN, Q_MIN);
        push_uniform_group(Q_NLSB, Q_LSB, Q_NLSB);
        // identity times signed values of every sign
        for (int i = 0; i < DIM; i++)
        begin
            r = uniform_row(Q_ZERO, Q_ZERO, 0, Q_ZERO);
            r.cols[i] = Q_ONE;
            r.cols[DIM+0] = 32'h1234_5678 ^ DW'(i);
            r.cols[DIM+1] = 32'hDEAD_BEEF + DW'(i);
            r.cols[DIM+2] = (i[0]) ? Q_MIN : Q_MAX;
            r.cols[DIM+3] = -(DW'(i) << 12);
            directed_rows.push_back(r);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        for (int g = 0; g < RAND_GROUPS; g++)
        begin
            for (int rr = 0; rr < DIM; rr++)
            begin
                for (int j = 0; j < 2*DIM; j++)
                    r.cols[j] = rand_q16();
                r.typed = 0;
                r.c_all = '0;
                send_word(r);
            end
        end
        s_tvalid <= 1'b0;

        while (product_rows_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mm4_pkg.sv
sv/mm4_ctrl.sv
sv/mm4_datapath.sv
sv/matrix_multiply_4x4_unit.sv
tb/sv/matrix_multiply_4x4_unit_tb.sv
